// File: hw/rtl/process_slot_table_top_macros.svh
// ----------------------------------------------------------------------------
// process slot table assertion macros
// shared concurrent check forms, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef PROCESS_SLOT_TABLE_TOP_MACROS_SVH
`define PROCESS_SLOT_TABLE_TOP_MACROS_SVH

// condition must hold in every cycle out of reset
`define PST_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pst check failed: invariant");

// antecedent in one cycle implies consequent in the same cycle
`define PST_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pst check failed: implication");

// antecedent in one cycle implies consequent in the next cycle
`define PST_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pst check failed: next-cycle implication");

`endif

// File: hw/rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// types and codes shared by the process slot table cells and top level
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int PID_W = 8;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    localparam int PID_BASE = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE = 2'd2;

    // command beat as it travels down the row of cells
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] parent_id;
        logic [PID_W-1:0] target_id;
        logic             hit;
        logic [PID_W-1:0] proc_id;
        logic [PID_W-1:0] found_parent;
        logic             found_alive;
        logic             found_parent_alive;
    } slot_pkt_t;

    // remove commit broadcast to every cell
    typedef struct packed {
        logic             valid;
        logic [PID_W-1:0] target_id;
    } commit_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [PID_W-1:0] proc_id;
        logic [PID_W-1:0] found_parent;
        logic             found_alive;
        logic             found_parent_alive;
    } rsp_t;

endpackage

// File: hw/rtl/pst_cell.sv
// ----------------------------------------------------------------------------
// pst_cell
// one process slot: holds its state, serves the passing command beat and
// applies remove commits
// ----------------------------------------------------------------------------
module pst_cell
    import pst_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  slot_pkt_t pkt_in,
    input  commit_t   commit,
    output slot_pkt_t pkt_out
);

    localparam logic [PID_W-1:0] MY_PID = PID_W'(IDX + PID_BASE);

    logic             used_reg, used_next;
    logic [PID_W-1:0] parent_reg, parent_next;
    logic             alive_reg, alive_next;
    logic             palive_reg, palive_next;
    slot_pkt_t        pkt_reg, pkt_next;
    logic             self_hit;

    assign self_hit = (pkt_in.target_id == MY_PID) && used_reg;

    always_comb
    begin
        pkt_next    = pkt_in;
        used_next   = used_reg;
        parent_next = parent_reg;
        alive_next  = alive_reg;
        palive_next = palive_reg;

        if (pkt_in.valid)
        begin
            unique case (pkt_in.cmd)
                CMD_INSERT:
                begin
                    // first free cell along the row claims the insert
                    if (!pkt_in.hit && !used_reg)
                    begin
                        used_next        = 1'b1;
                        parent_next      = pkt_in.parent_id;
                        alive_next       = 1'b1;
                        palive_next      = 1'b1;
                        pkt_next.hit     = 1'b1;
                        pkt_next.proc_id = MY_PID;
                    end
                end
                CMD_REMOVE:
                begin
                    if (self_hit)
                        pkt_next.hit = 1'b1;
                end
                CMD_FIND:
                begin
                    if (self_hit)
                    begin
                        pkt_next.hit                = 1'b1;
                        pkt_next.proc_id            = MY_PID;
                        pkt_next.found_parent       = parent_reg;
                        pkt_next.found_alive        = alive_reg;
                        pkt_next.found_parent_alive = palive_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (commit.valid)
        begin
            // child pass first, then the removed process itself
            if (used_reg && (parent_reg == commit.target_id))
            begin
                if (alive_reg)
                    palive_next = 1'b0;
                else
                    used_next = 1'b0;
            end
            if ((commit.target_id == MY_PID) && used_next)
            begin
                if (palive_next)
                    alive_next = 1'b0;
                else
                    used_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            pkt_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            pkt_reg  <= pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        parent_reg <= parent_next;
        alive_reg  <= alive_next;
        palive_reg <= palive_next;
    end

    assign pkt_out = pkt_reg;

endmodule

// File: hw/rtl/process_slot_table_top.sv
// ----------------------------------------------------------------------------
// process_slot_table_top
// process slot table built as a row of slot cells walked by each command
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  req     | req_valid/req_ready, cmd, parent_id,      | command beat in
//          | target_id                                 |
//  rsp     | rsp_valid/rsp_ready, status, proc_id,     | result beat out
//          | found_parent, found_alive, found_parent_alive |
//
//  a command walks the row one cell per cycle, then passes through the pending
//  stage into the result register; req_ready rises in the cycle the result
//  register is loaded, so a new beat is taken only once the previous result
//  has left the pending stage, never while it waits there on rsp_ready.
//  a remove is committed to all cells in the cycle the beat leaves the row.
//  reset empties the table at once, no clearing pass.
//  a stalled result holds in a pending stage, and req_ready stays low, while
//  the result register is still held by rsp.
// ----------------------------------------------------------------------------
`include "process_slot_table_top_macros.svh"

module process_slot_table_top
    import pst_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [CMD_W-1:0] cmd,
    input  logic [PID_W-1:0] parent_id,
    input  logic [PID_W-1:0] target_id,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic [ST_W-1:0]  status,
    output logic [PID_W-1:0] proc_id,
    output logic [PID_W-1:0] found_parent,
    output logic             found_alive,
    output logic             found_parent_alive
);

    slot_pkt_t        chain [SLOTS+1];
    logic [SLOTS-1:0] chain_vld;
    commit_t          commit;
    slot_pkt_t        tail;

    logic busy_reg, busy_next;
    logic pend_valid_reg, pend_valid_next;
    rsp_t pend_reg, pend_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;
    rsp_t result;
    logic pend_move;

    assign req_ready = !busy_reg;

    always_comb
    begin
        chain[0]           = '0;
        chain[0].valid     = req_valid && req_ready;
        chain[0].cmd       = cmd;
        chain[0].parent_id = parent_id;
        chain[0].target_id = target_id;
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            pst_cell #(
                .IDX (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .pkt_in  (chain[g]),
                .commit  (commit),
                .pkt_out (chain[g+1])
            );
            assign chain_vld[g] = chain[g+1].valid;
        end
    endgenerate

    assign tail = chain[SLOTS];

    assign commit.valid     = tail.valid && (tail.cmd == CMD_REMOVE) && tail.hit;
    assign commit.target_id = tail.target_id;

    always_comb
    begin
        result        = '0;
        result.status = ST_NONE;
        unique case (tail.cmd)
            CMD_INSERT:
            begin
                result.status  = tail.hit ? ST_OK : ST_FULL;
                result.proc_id = tail.hit ? tail.proc_id : '0;
            end
            CMD_REMOVE:
            begin
                result.status = tail.hit ? ST_OK : ST_NONE;
            end
            CMD_FIND:
            begin
                if (tail.hit)
                begin
                    result.status             = ST_OK;
                    result.proc_id            = tail.proc_id;
                    result.found_parent       = tail.found_parent;
                    result.found_alive        = tail.found_alive;
                    result.found_parent_alive = tail.found_parent_alive;
                end
            end
            default:
            begin
                result.status = ST_NONE;
            end
        endcase
    end

    assign pend_move = pend_valid_reg && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        if (pend_move)
        begin
            rsp_valid_next  = 1'b1;
            rsp_next        = pend_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end

        if (tail.valid)
        begin
            pend_valid_next = 1'b1;
            pend_next       = result;
        end

        if (chain[0].valid)
            busy_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid          = rsp_valid_reg;
    assign status             = rsp_reg.status;
    assign proc_id            = rsp_reg.proc_id;
    assign found_parent       = rsp_reg.found_parent;
    assign found_alive        = rsp_reg.found_alive;
    assign found_parent_alive = rsp_reg.found_parent_alive;

    // only one command in flight along the row
    `PST_ASSERT_ALWAYS(a_one_beat_in_row, $onehot0({chain_vld, pend_valid_reg}))
    `PST_ASSERT_IMPL(a_commit_while_busy, commit.valid, busy_reg)
    `PST_ASSERT_NEXT(a_accept_sets_busy, req_valid && req_ready, busy_reg && !req_ready)
    `PST_ASSERT_IMPL(a_full_no_pid, rsp_valid && (status == ST_FULL), proc_id == '0)

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the process slot table: a short table of directed
// commands, then random insert/remove/find/unused traffic in fill and drain phases,
// every result beat compared against its directed expectation or a model kept here
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    localparam int SLOTS        = 32;
    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_WAIT     = 19;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam rsp_t RSP_NONE = '{ST_NONE, 8'd0, 8'd0, 1'b0, 1'b0};
    localparam rsp_t RSP_DONE = '{ST_OK, 8'd0, 8'd0, 1'b0, 1'b0};

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] parent_id;
        logic [PID_W-1:0] target_id;
        bit               typed;
        rsp_t             rsp;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    logic [CMD_W-1:0] cmd;
    logic [PID_W-1:0] parent_id;
    logic [PID_W-1:0] target_id;
    logic             rsp_valid;
    logic             rsp_ready;
    logic [ST_W-1:0]  status;
    logic [PID_W-1:0] proc_id;
    logic [PID_W-1:0] found_parent;
    logic             found_alive;
    logic             found_parent_alive;

    // model of the slot table
    bit               tbl_used   [SLOTS];
    logic [PID_W-1:0] tbl_parent [SLOTS];
    bit               tbl_alive  [SLOTS];
    bit               tbl_palive [SLOTS];

    rsp_t      pending_results[$];
    stim_row_t directed_rows[N_DIRECTED];
    bit        row_typed;
    rsp_t      row_rsp;
    bit        send_calm;

    int errors;
    int n_checked;
    int n_full;
    int n_cmd[4];
    int idle_cycles;

    process_slot_table_top #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .cmd               (cmd),
        .parent_id         (parent_id),
        .target_id         (target_id),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .status            (status),
        .proc_id           (proc_id),
        .found_parent      (found_parent),
        .found_alive       (found_alive),
        .found_parent_alive(found_parent_alive)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_slot(input int i);
        tbl_used[i]   = 1'b0;
        tbl_parent[i] = '0;
        tbl_alive[i]  = 1'b0;
        tbl_palive[i] = 1'b0;
    endfunction

    function automatic rsp_t apply_command(input logic [CMD_W-1:0] c,
                                           input logic [PID_W-1:0] par,
                                           input logic [PID_W-1:0] tgt);
        rsp_t r;
        int   s;
        r = RSP_NONE;
        s = (tgt >= PID_BASE && tgt < SLOTS + PID_BASE) ? int'(tgt) - PID_BASE : -1;
        case (c)
            CMD_INSERT:
            begin
                r.status = ST_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!tbl_used[i] && r.status == ST_FULL)
                    begin
                        tbl_used[i]   = 1'b1;
                        tbl_parent[i] = par;
                        tbl_alive[i]  = 1'b1;
                        tbl_palive[i] = 1'b1;
                        r.status      = ST_OK;
                        r.proc_id     = PID_W'(i + PID_BASE);
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (s >= 0 && tbl_used[s])
                begin
                    // children first, matched on pid
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (tbl_used[i] && tbl_parent[i] == tgt)
                        begin
                            if (tbl_alive[i])
                                tbl_palive[i] = 1'b0;
                            else
                                clear_slot(i);
                        end
                    end
                    if (tbl_used[s])
                    begin
                        if (tbl_palive[s])
                            tbl_alive[s] = 1'b0;
                        else
                            clear_slot(s);
                    end
                    r = RSP_DONE;
                end
            end
            CMD_FIND:
            begin
                if (s >= 0 && tbl_used[s])
                begin
                    r.status             = ST_OK;
                    r.proc_id            = tgt;
                    r.found_parent       = tbl_parent[s];
                    r.found_alive        = tbl_alive[s];
                    r.found_parent_alive = tbl_palive[s];
                end
            end
            default:
            begin
                r = RSP_NONE;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endtask

    task automatic send_beat(input stim_row_t row);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        cmd       <= row.cmd;
        parent_id <= row.parent_id;
        target_id <= row.target_id;
        row_typed = row.typed;
        row_rsp   = row.rsp;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
    endtask

    // predict on every accepted command beat, check every accepted result beat
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (req_valid && req_ready)
            begin
                moved = 1'b1;
                got = apply_command(cmd, parent_id, target_id);
                pending_results.push_back(row_typed ? row_rsp : got);
                n_cmd[cmd]++;
                if (got.status == ST_FULL)
                    n_full++;
            end
            if (rsp_valid && rsp_ready)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing outstanding: status %0d proc_id %0d",
                           status, proc_id);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("proc_id", want.proc_id, proc_id);
                    check_field("found_parent", want.found_parent, found_parent);
                    check_field("found_alive", want.found_alive, found_alive);
                    check_field("found_parent_alive", want.found_parent_alive,
                                found_parent_alive);
                    n_checked++;
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no beat moved for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int hold;
        int beats;
        bit calm;
        rsp_ready = 1'b0;
        beats     = 0;
        calm      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            beats++;
            hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (hold)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
        end
    end

    initial
    begin
        stim_row_t row;
        int        live[$];
        int        next_free;
        int        phase_left;
        int        r;
        bit        filling;

        req_valid   = 1'b0;
        cmd         = CMD_INSERT;
        parent_id   = '0;
        target_id   = '0;
        row_typed   = 1'b0;
        row_rsp     = RSP_NONE;
        send_calm   = 1'b0;
        errors      = 0;
        n_checked   = 0;
        n_full      = 0;
        n_cmd       = '{0, 0, 0, 0};
        idle_cycles = 0;
        rst_n       = 1'b0;

        directed_rows = '{
            '{CMD_FIND,   8'hAA, 8'd3,   1'b1, RSP_NONE},   // empty table
            '{CMD_REMOVE, 8'h55, 8'd3,   1'b1, RSP_NONE},
            '{CMD_UNUSED, 8'hFF, 8'hFF,  1'b1, RSP_NONE},
            // process that is its own parent
            '{CMD_INSERT, 8'd3,  8'd0,   1'b1, '{ST_OK, 8'd3, 8'd0, 1'b0, 1'b0}},
            '{CMD_FIND,   8'd0,  8'd3,   1'b1, '{ST_OK, 8'd3, 8'd3, 1'b1, 1'b1}},
            '{CMD_REMOVE, 8'd0,  8'd3,   1'b1, RSP_DONE},
            '{CMD_FIND,   8'd0,  8'd3,   1'b1, RSP_NONE},
            // small tree: 3 -> 4 -> 6, and 5 under an out-of-range parent
            '{CMD_INSERT, 8'd0,  8'hFF,  1'b1, '{ST_OK, 8'd3, 8'd0, 1'b0, 1'b0}},
            '{CMD_INSERT, 8'd3,  8'd0,   1'b1, '{ST_OK, 8'd4, 8'd0, 1'b0, 1'b0}},
            '{CMD_INSERT, 8'hFF, 8'd0,   1'b1, '{ST_OK, 8'd5, 8'd0, 1'b0, 1'b0}},
            '{CMD_INSERT, 8'd4,  8'd0,   1'b1, '{ST_OK, 8'd6, 8'd0, 1'b0, 1'b0}},
            '{CMD_REMOVE, 8'd0,  8'd4,   1'b0, RSP_NONE},
            '{CMD_FIND,   8'd0,  8'd4,   1'b0, RSP_NONE},   // dead but kept
            '{CMD_FIND,   8'd0,  8'd6,   1'b0, RSP_NONE},   // orphaned
            '{CMD_REMOVE, 8'd0,  8'd3,   1'b0, RSP_NONE},
            '{CMD_FIND,   8'd0,  8'd4,   1'b0, RSP_NONE},
            '{CMD_REMOVE, 8'd0,  8'd6,   1'b0, RSP_NONE},
            // pids that name no slot, or an empty one
            '{CMD_FIND,   8'h55, 8'd0,   1'b1, RSP_NONE},
            '{CMD_FIND,   8'hAA, 8'd2,   1'b1, RSP_NONE},
            '{CMD_FIND,   8'd0,  8'd34,  1'b1, RSP_NONE},
            '{CMD_FIND,   8'd0,  8'd35,  1'b1, RSP_NONE},
            '{CMD_REMOVE, 8'd0,  8'hFF,  1'b1, RSP_NONE},
            '{CMD_REMOVE, 8'hFF, 8'd0,   1'b1, RSP_NONE},
            '{CMD_FIND,   8'd0,  8'd5,   1'b0, RSP_NONE},
            '{CMD_UNUSED, 8'd0,  8'd5,   1'b1, RSP_NONE}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_beat(directed_rows[i]);

        filling    = 1'b0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(40, 160);
                send_calm  = ($urandom_range(0, 3) == 0);
            end
            phase_left--;

            live.delete();
            next_free = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_used[i])
                    live.push_back(i + PID_BASE);
                else if (next_free < 0)
                    next_free = i + PID_BASE;
            end

            r = $urandom_range(0, 99);
            if (filling)
                row.cmd = (r < 60) ? CMD_INSERT : (r < 75) ? CMD_REMOVE :
                          (r < 95) ? CMD_FIND : CMD_UNUSED;
            else
                row.cmd = (r < 15) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                          (r < 95) ? CMD_FIND : CMD_UNUSED;

            if (live.size() > 0 && $urandom_range(0, 3) != 0)
                row.target_id = PID_W'(live[$urandom_range(0, live.size() - 1)]);
            else
                row.target_id = PID_W'($urandom_range(0, 255));

            // parents mostly live or in range, so dead processes get reaped
            r = $urandom_range(0, 99);
            if (row.cmd != CMD_INSERT)
                row.parent_id = PID_W'($urandom_range(0, 255));
            else if (r < 55 && live.size() > 0)
                row.parent_id = PID_W'(live[$urandom_range(0, live.size() - 1)]);
            else if (r < 70 && next_free >= 0)
                row.parent_id = PID_W'(next_free);
            else if (r < 99)
                row.parent_id = PID_W'($urandom_range(PID_BASE, SLOTS + PID_BASE - 1));
            else
                row.parent_id = PID_W'($urandom_range(0, 255));

            row.typed = 1'b0;
            row.rsp   = RSP_NONE;
            send_beat(row);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("commands sent: %0d insert (%0d on a full table), %0d remove, %0d find, %0d unused",
                 n_cmd[CMD_INSERT], n_full, n_cmd[CMD_REMOVE], n_cmd[CMD_FIND],
                 n_cmd[CMD_UNUSED]);
        $display("result beats checked: %0d, mismatches: %0d", n_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
